// ===== design/ftacc_pkg.sv =====
`default_nettype none

package ftacc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;

  // Register reset values
  localparam logic [31:0] FREQ_RESET = 32'd1000000;
  localparam logic [5:0]  MIN_RESET  = 6'd12;

  // Request action codes
  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_FRAME = 1'b1;

  localparam logic [5:0] TICKS_MAX = 6'd63;
  localparam logic [3:0] TENTHS    = 4'd10;

  typedef struct packed {
    logic        action;
    logic [63:0] counter_now;
  } item_t;

  typedef struct packed {
    logic [5:0]  ticks_issued;
    logic [31:0] tick_count;
    logic [31:0] tenth_seconds;
    logic [31:0] whole_seconds;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic diff;
    logic start_clear;
    logic zero_ticks;
    logic advance;
    logic clamp_load;
    logic tdiv_load;
    logic div_step;
    logic sum_load;
    logic issue;
    logic sec_mul;
    logic sec_est;
    logic sec_fix;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic freq_zero;
    logic clamp;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/ftacc_ctrl.sv =====
`default_nettype none

module ftacc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire ftacc_pkg::status_t stat,
  output ftacc_pkg::cmd_t         cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_TDIV  = 10'b00_0000_1000,
    S_SUM   = 10'b00_0001_0000,
    S_ISSUE = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_EST   = 10'b00_1000_0000,
    S_FIX   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  // Sequence one request through the datapath
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_start) begin
          cmd.start_clear = 1'b1;
          state_next      = S_MUL;
        end else if (stat.freq_zero) begin
          cmd.zero_ticks = 1'b1;
          state_next     = S_MUL;
        end else if (stat.clamp) begin
          cmd.advance    = 1'b1;
          cmd.clamp_load = 1'b1;
          state_next     = S_SUM;
        end else begin
          cmd.advance   = 1'b1;
          cmd.tdiv_load = 1'b1;
          state_next    = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.sec_mul = 1'b1;
        state_next  = S_EST;
      end
      S_EST: begin
        cmd.sec_est = 1'b1;
        state_next  = S_FIX;
      end
      S_FIX: begin
        cmd.sec_fix = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ftacc_dp.sv =====
`default_nettype none

module ftacc_dp #(
  parameter int TICK_HZ   = 136,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ftacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data,
  input  wire ftacc_pkg::item_t                item,
  input  wire logic                            result_ready,
  output logic                                 result_valid,
  output ftacc_pkg::result_t                   result,
  input  wire ftacc_pkg::cmd_t                 cmd,
  output ftacc_pkg::status_t                   stat
);

  localparam int ACC_W = FRAC_BITS + 8;
  localparam int DQ_W  = ACC_W;
  localparam int CNT_W = $clog2(DQ_W + 1);
  localparam int HZ_W  = $clog2(TICK_HZ + 1);
  localparam int PW    = 32 + HZ_W;
  localparam int TW    = ACC_W - 1 - FRAC_BITS;

  localparam logic [ACC_W-1:0] CLAMP_INC = ACC_W'((64'(TICK_HZ) << FRAC_BITS) >> 2);
  localparam logic [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  // Reciprocal of TICK_HZ; the quotient estimate is short by at most one
  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / 64'(TICK_HZ));

  logic [31:0]       freq;
  logic [5:0]        min_ticks;
  logic              action_r;
  logic [63:0]       now_r;
  logic [63:0]       last_reading;
  logic [63:0]       elapsed;
  logic [ACC_W-1:0]  frac_acc;
  logic [ACC_W-1:0]  sum;
  logic [31:0]       total_ticks;
  logic [31:0]       whole;
  logic [5:0]        ticks;

  // Restoring divider for the tick increment
  logic [31:0]       dv;
  logic [31:0]       rem;
  logic [DQ_W-1:0]   quo;
  logic [DQ_W-1:0]   sh;
  logic [CNT_W-1:0]  cnt;

  // Seconds by reciprocal multiply and one correction
  logic [63:0]       sec_prod;
  logic [31:0]       sec_q;
  logic [31:0]       sec_r;
  logic [31:0]       q_by_hz;
  logic [HZ_W-1:0]   sec_rem;
  logic [3:0]        tdigit;

  logic [PW-1:0]     prod;
  logic [DQ_W-1:0]   sh_tick;
  logic [32:0]       part;
  logic [33:0]       trial;
  logic              fits;
  logic [31:0]       rem_next;
  logic [HZ_W+3:0]   rm10;
  logic [ACC_W+1:0]  sum_wide;
  logic [ACC_W-1:0]  sum_sat;
  logic [TW-1:0]     t_floor;
  logic [5:0]        t_cap;
  logic [5:0]        t_fin;
  logic [ACC_W:0]    diff;
  logic [ACC_W-1:0]  acc_left;
  logic [31:0]       tenths;

  // Scaled elapsed counts and the dividend bits that feed the tick division
  assign prod    = PW'(elapsed[31:0]) * PW'(TICK_HZ);
  assign sh_tick = {prod[7:0], {FRAC_BITS{1'b0}}};

  // One quotient bit per step
  assign part     = {rem, sh[DQ_W-1]};
  assign trial    = {1'b0, part} - {2'b00, dv};
  assign fits     = !trial[33];
  assign rem_next = fits ? trial[31:0] : part[31:0];

  // Estimated quotient times TICK_HZ, never above the total
  assign q_by_hz = sec_prod[63:32] * 32'(TICK_HZ);

  // Tenths digit from the seconds remainder
  assign rm10 = (HZ_W + 4)'(sec_rem) * (HZ_W + 4)'(ftacc_pkg::TENTHS);
  always_comb begin
    tdigit = '0;
    for (int k = 1; k < int'(ftacc_pkg::TENTHS); k++) begin
      if (rm10 >= (HZ_W + 4)'(k * TICK_HZ)) tdigit = 4'(k);
    end
  end

  // Accumulate and saturate
  assign sum_wide = {{2{frac_acc[ACC_W-1]}}, frac_acc} + {2'b00, quo[ACC_W-1:0]};
  always_comb begin
    if ((sum_wide[ACC_W+1] == sum_wide[ACC_W]) && (sum_wide[ACC_W] == sum_wide[ACC_W-1])) begin
      sum_sat = sum_wide[ACC_W-1:0];
    end else if (sum_wide[ACC_W+1]) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = ACC_MAX;
    end
  end

  // Floor, cap and apply the per-frame minimum
  assign t_floor = sum[ACC_W-1] ? '0 : sum[ACC_W-2:FRAC_BITS];
  assign t_cap   = (t_floor > TW'(ftacc_pkg::TICKS_MAX)) ? ftacc_pkg::TICKS_MAX : t_floor[5:0];
  assign t_fin   = (t_cap < min_ticks) ? min_ticks : t_cap;

  // Take the issued ticks back off; only the low bound can be crossed
  assign diff     = {sum[ACC_W-1], sum} - (ACC_W + 1)'({t_fin, {FRAC_BITS{1'b0}}});
  assign acc_left = (diff[ACC_W] != diff[ACC_W-1]) ? ACC_MIN : diff[ACC_W-1:0];

  assign tenths = {whole[28:0], 3'b000} + {whole[30:0], 1'b0} + 32'(tdigit);

  assign stat.is_start  = (action_r == ftacc_pkg::ACTION_START);
  assign stat.freq_zero = (freq == 32'd0);
  assign stat.clamp     = (|elapsed[63:32]) || ({elapsed[31:0], 2'b00} > {2'b00, freq});
  assign stat.div_last  = (cnt == CNT_W'(1));
  assign stat.out_free  = !result_valid || result_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq      <= ftacc_pkg::FREQ_RESET;
      min_ticks <= ftacc_pkg::MIN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ftacc_pkg::CFG_FREQ) begin
        freq <= cfg_data;
      end else if (cfg_index == ftacc_pkg::CFG_MIN) begin
        min_ticks <= cfg_data[5:0];
      end
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading <= '0;
      frac_acc     <= '0;
      total_ticks  <= '0;
    end else if (cmd.start_clear) begin
      last_reading <= now_r;
      frac_acc     <= '0;
      total_ticks  <= '0;
    end else begin
      if (cmd.advance) last_reading <= now_r;
      if (cmd.issue) begin
        frac_acc    <= acc_left;
        total_ticks <= total_ticks + 32'(t_fin);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= item.action;
      now_r    <= item.counter_now;
    end
    if (cmd.diff) elapsed <= now_r - last_reading;
    if (cmd.sum_load) sum <= sum_sat;
    if (cmd.issue) begin
      ticks <= t_fin;
    end else if (cmd.start_clear || cmd.zero_ticks) begin
      ticks <= '0;
    end
  end

  // Split the total into whole seconds and a remainder
  always_ff @(posedge clk) begin
    if (cmd.sec_mul) sec_prod <= 64'(total_ticks) * 64'(RECIP);
    if (cmd.sec_est) begin
      sec_q <= sec_prod[63:32];
      sec_r <= total_ticks - q_by_hz;
    end
    if (cmd.sec_fix) begin
      if (sec_r >= 32'(TICK_HZ)) begin
        whole   <= sec_q + 32'd1;
        sec_rem <= HZ_W'(sec_r - 32'(TICK_HZ));
      end else begin
        whole   <= sec_q;
        sec_rem <= HZ_W'(sec_r);
      end
    end
  end

  // Divider load and step
  always_ff @(posedge clk) begin
    if (cmd.tdiv_load) begin
      dv  <= freq;
      rem <= 32'(prod >> 8);
      sh  <= sh_tick;
      quo <= '0;
      cnt <= CNT_W'(ACC_W);
    end else if (cmd.clamp_load) begin
      quo <= DQ_W'(CLAMP_INC);
    end else if (cmd.div_step) begin
      rem <= rem_next;
      sh  <= {sh[DQ_W-2:0], 1'b0};
      quo <= {quo[DQ_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.ticks_issued  <= ticks;
      result.tick_count    <= total_ticks;
      result.tenth_seconds <= tenths;
      result.whole_seconds <= whole;
    end
  end

endmodule

`default_nettype wire

// ===== design/frame_tick_accumulator_unit.sv =====
`default_nettype none

// Channel   Signals                                Moves
// item      item_valid / item_ready / item         action, counter_now
// result    result_valid / result_ready / result   ticks, total, tenths, seconds
// config    cfg_we / cfg_index / cfg_data          counter_frequency, min_frame_ticks
//
// A frame request that needs the division runs the bit-serial divider for the
// tick increment through FRAC_BITS + 8 steps; seconds and tenths then follow
// from a reciprocal multiply, an estimate and one correction. A clamped frame
// skips the division; start and zero-frequency requests skip it as well.
// Reset loads the configuration defaults, clears the accumulator, tick total,
// last reading and result_valid, and puts the controller in its idle state.
// A waiting result holds the block in its last step; a new request is taken,
// one at a time, while an earlier result still waits in the output register.

module frame_tick_accumulator_unit #(
  parameter int TICK_HZ   = 136,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ftacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire ftacc_pkg::item_t                item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output ftacc_pkg::result_t                   result
);

  ftacc_pkg::cmd_t    cmd;
  ftacc_pkg::status_t stat;

  ftacc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ftacc_dp #(
    .TICK_HZ   (TICK_HZ),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire
